// ===== design/npci_pkg.sv =====
package npci_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_REG_W  = 9;
  localparam int FIELD_W    = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_LENGTH = 2'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

endpackage

// ===== design/nearest_palette_color_index.sv =====
// write item: stored in the palette memory on acceptance, no result
// query item: one palette read per cycle from the single read port, through the read data,
//   distance and running-minimum registers to the output register; next item taken once back in idle,
//   which waits while the output register still holds an unaccepted item
// a finished result waits in the output register while the next item is accepted
// synchronous active-low reset clears control state and sets palette_length to 1;
//   palette contents are undefined until written
module nearest_palette_color_index #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int CHANNEL_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,    // entry_index, red, green, blue
  input  logic                               in_tuser,    // operation
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,   // nearest_index
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [npci_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [npci_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [npci_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int IDX_W  = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int LEN_W  = ($clog2(PALETTE_ENTRIES + 1) > npci_pkg::LEN_REG_W) ?
                          $clog2(PALETTE_ENTRIES + 1) : npci_pkg::LEN_REG_W;
  localparam int CH_W   = CHANNEL_BITS;
  localparam int MEM_W  = 3 * CH_W;
  localparam int DIST_W = CH_W + 2;

  npci_pkg::state_t state_r, state_nxt;

  logic [npci_pkg::LEN_REG_W-1:0] len_r;
  logic                           cfg_we;

  logic [7:0]      f_index, f_red, f_green, f_blue;
  logic [CH_W-1:0] red_m, green_m, blue_m;
  logic            in_acc, mem_we, query_acc;

  logic [LEN_W-1:0] len_ext, lim;
  logic [IDX_W-1:0] last_r, rd_addr_r;
  logic [CH_W-1:0]  q_red_r, q_green_r, q_blue_r;

  logic [MEM_W-1:0] pal_mem [PALETTE_ENTRIES];
  logic [MEM_W-1:0] rd_data_r;
  logic             issue;

  logic             s1_v_r, s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r, s2_last_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [DIST_W-1:0] dist_r, best_dist_r;
  logic [IDX_W-1:0] best_idx_r;

  logic [CH_W-1:0]   m_red, m_green, m_blue, d_red, d_green, d_blue;
  logic [DIST_W-1:0] dist_nxt;

  logic       out_tvalid_r;
  logic [7:0] out_idx_r;
  logic       out_free;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == npci_pkg::REG_PALETTE_LENGTH);
  assign cfg_prdata = (cfg_paddr == npci_pkg::REG_PALETTE_LENGTH) ?
                      npci_pkg::CFG_DATA_W'(len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= npci_pkg::LEN_REG_W'(1);
    end else if (cfg_we) begin
      len_r <= cfg_pwdata[npci_pkg::LEN_REG_W-1:0];
    end
  end

  // input unpacking
  assign f_index = in_tdata[7:0];
  assign f_red   = in_tdata[15:8];
  assign f_green = in_tdata[23:16];
  assign f_blue  = in_tdata[31:24];
  assign red_m   = CH_W'(f_red);
  assign green_m = CH_W'(f_green);
  assign blue_m  = CH_W'(f_blue);

  assign in_tready = (state_r == npci_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mem_we    = in_acc && (in_tuser == npci_pkg::OP_WRITE) &&
                     (LEN_W'(f_index) < LEN_W'(PALETTE_ENTRIES));
  assign query_acc = in_acc && (in_tuser == npci_pkg::OP_QUERY);

  // searched length clamped to 1..PALETTE_ENTRIES
  assign len_ext = LEN_W'(len_r);
  always_comb begin
    priority if (len_ext == '0) begin
      lim = LEN_W'(1);
    end else if (len_ext > LEN_W'(PALETTE_ENTRIES)) begin
      lim = LEN_W'(PALETTE_ENTRIES);
    end else begin
      lim = len_ext;
    end
  end

  // palette memory
  assign issue = (state_r == npci_pkg::ST_SCAN);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pal_mem[IDX_W'(f_index)] <= {blue_m, green_m, red_m};
    end
    rd_data_r <= pal_mem[rd_addr_r];
  end

  // query capture and read address
  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_red_r   <= red_m;
      q_green_r <= green_m;
      q_blue_r  <= blue_m;
      last_r    <= IDX_W'(lim - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
    end else if (query_acc) begin
      rd_addr_r <= '0;
    end else if (issue) begin
      rd_addr_r <= IDX_W'(rd_addr_r + IDX_W'(1));
    end
  end

  // distance of the entry read last cycle
  assign m_red   = rd_data_r[CH_W-1:0];
  assign m_green = rd_data_r[2*CH_W-1:CH_W];
  assign m_blue  = rd_data_r[3*CH_W-1:2*CH_W];
  assign d_red   = (m_red > q_red_r) ? (m_red - q_red_r) : (q_red_r - m_red);
  assign d_green = (m_green > q_green_r) ? (m_green - q_green_r) : (q_green_r - m_green);
  assign d_blue  = (m_blue > q_blue_r) ? (m_blue - q_blue_r) : (q_blue_r - m_blue);
  assign dist_nxt = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= rd_addr_r;
    s1_last_r <= (rd_addr_r == last_r);
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    dist_r    <= dist_nxt;
  end

  // running minimum, first index wins ties
  always_ff @(posedge clk) begin
    if (s2_v_r && ((s2_idx_r == '0) || (dist_r < best_dist_r))) begin
      best_dist_r <= dist_r;
      best_idx_r  <= s2_idx_r;
    end
  end

  // sequencer
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npci_pkg::ST_IDLE: begin
        if (query_acc) state_nxt = npci_pkg::ST_SCAN;
      end
      npci_pkg::ST_SCAN: begin
        if (rd_addr_r == last_r) state_nxt = npci_pkg::ST_DRAIN;
      end
      npci_pkg::ST_DRAIN: begin
        if (s2_v_r && s2_last_r) state_nxt = npci_pkg::ST_HOLD;
      end
      npci_pkg::ST_HOLD: begin
        if (out_free) state_nxt = npci_pkg::ST_IDLE;
      end
      default: state_nxt = npci_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npci_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == npci_pkg::ST_HOLD) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == npci_pkg::ST_HOLD) && out_free) begin
      out_idx_r <= 8'(best_idx_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_idx_r;

`ifndef NO_ASSERTIONS
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == npci_pkg::ST_HOLD))
    else $error("result shown without a finished scan");

  a_s2_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == npci_pkg::ST_SCAN) || (state_r == npci_pkg::ST_DRAIN))
    else $error("distance stage busy outside a scan");

  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == npci_pkg::ST_SCAN) |-> (rd_addr_r <= last_r))
    else $error("read address beyond searched length");

  a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_last_r) |-> (state_r == npci_pkg::ST_DRAIN))
    else $error("last entry compared outside drain");
`endif

endmodule

// ===== tb/sv/tb_nearest_palette_color_index.sv =====
module tb_nearest_palette_color_index;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ITEMS_TARGET    = 1850;
  localparam int SETTLE_CYCLES   = 280;
  localparam int CYCLE_LIMIT     = 10000000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;    // entry_index, red, green, blue
  logic                            in_tuser;    // operation
  logic                            out_tvalid;
  logic                            out_tready;
  logic [7:0]                      out_tdata;   // nearest_index
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [npci_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [npci_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [npci_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  rgb_t       palette_copy [PALETTE_ENTRIES];
  bit         written [PALETTE_ENTRIES];
  logic [8:0] length_cfg;
  logic [7:0] index_due [$];
  bit         steady_flow;
  int         items_sent;
  int         mismatches;
  int         cycle_count;

  nearest_palette_color_index dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rgb_t rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  function automatic int active_span();
    if (length_cfg == 0) return 1;
    if (length_cfg > PALETTE_ENTRIES) return PALETTE_ENTRIES;
    return length_cfg;
  endfunction

  function automatic int channel_gap(input rgb_t a, input rgb_t b);
    int dr, dg, db;
    dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
    return dr + dg + db;
  endfunction

  // first entry with the smallest summed channel distance
  function automatic logic [7:0] nearest_entry(input rgb_t c);
    int best_at, best_dist, cur_gap;
    best_at = 0;
    best_dist = channel_gap(palette_copy[0], c);
    for (int i = 1; i < active_span(); i++) begin
      cur_gap = channel_gap(palette_copy[i], c);
      if (cur_gap < best_dist) begin
        best_dist = cur_gap;
        best_at = i;
      end
    end
    return best_at[7:0];
  endfunction

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [7:0] rail_level();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hFE;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic rgb_t query_color();
    int roll;
    rgb_t c;
    roll = $urandom_range(0, 99);
    c = rgb_t'($urandom);
    if (roll < 20) begin
      c = palette_copy[$urandom_range(0, active_span() - 1)];
    end else if (roll < 40) begin
      c = palette_copy[$urandom_range(0, active_span() - 1)];
      c.red   = c.red + 8'($urandom_range(0, 6)) - 8'd3;
      c.green = c.green + 8'($urandom_range(0, 6)) - 8'd3;
      c.blue  = c.blue + 8'($urandom_range(0, 6)) - 8'd3;
    end else if (roll < 55) begin
      c = rgb(rail_level(), rail_level(), rail_level());
    end
    return c;
  endfunction

  function automatic void report_mismatch(input string what, input int want, input int got);
    if (mismatches < 10) $display("%s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endfunction

  task automatic send_item(input logic op, input logic [7:0] idx, input rgb_t color);
    int gap;
    gap = steady_flow ? 0 : gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {color, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == npci_pkg::OP_WRITE) begin
      palette_copy[idx] = color;
      written[idx] = 1'b1;
    end else begin
      index_due = {index_due, nearest_entry(color)};
    end
  endtask

  // stop sending, let every query finish, then give a trailing write time to land
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (index_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [8:0] value,
                            output logic [npci_pkg::CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= npci_pkg::REG_PALETTE_LENGTH;
    cfg_pwdata  <= npci_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_length_reg();
    logic [npci_pkg::CFG_DATA_W-1:0] rdata;
    cfg_access(1'b0, 9'd0, rdata);
    if (rdata[npci_pkg::LEN_REG_W-1:0] !== length_cfg)
      report_mismatch("palette_length readback", length_cfg,
                      rdata[npci_pkg::LEN_REG_W-1:0]);
  endtask

  task automatic set_length(input logic [8:0] value);
    logic [npci_pkg::CFG_DATA_W-1:0] rdata;
    settle();
    cfg_access(1'b1, value, rdata);
    length_cfg = value;
    check_length_reg();
  endtask

  // every entry a query can reach must hold a written color
  task automatic fill_span();
    for (int i = 0; i < active_span(); i++)
      if (!written[i]) send_item(npci_pkg::OP_WRITE, 8'(i), rgb_t'($urandom));
  endtask

  task automatic test_reset_length();
    check_length_reg();
    send_item(npci_pkg::OP_WRITE, 8'd0, rgb(8'h10, 8'h20, 8'h30));
    send_item(npci_pkg::OP_QUERY, 8'hFF, rgb(8'h10, 8'h20, 8'h30));
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'hFF, 8'h00, 8'hFF));
  endtask

  task automatic test_directed_colors();
    set_length(9'd4);
    send_item(npci_pkg::OP_WRITE, 8'd0, rgb(8'h00, 8'h00, 8'h00));
    send_item(npci_pkg::OP_WRITE, 8'd1, rgb(8'hFF, 8'hFF, 8'hFF));
    send_item(npci_pkg::OP_WRITE, 8'd2, rgb(8'h80, 8'h80, 8'h80));
    send_item(npci_pkg::OP_WRITE, 8'd3, rgb(8'h80, 8'h80, 8'h80));
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'h00, 8'h00, 8'h00));
    send_item(npci_pkg::OP_QUERY, 8'hFF, rgb(8'hFF, 8'hFF, 8'hFF));
    // duplicate entries: lowest index wins
    send_item(npci_pkg::OP_QUERY, 8'h5A, rgb(8'h80, 8'h80, 8'h80));
    send_item(npci_pkg::OP_QUERY, 8'hA5, rgb(8'h7F, 8'h80, 8'h81));
    // equal distance to entries 0 and 2
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'h40, 8'h40, 8'h40));
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'hC0, 8'hC0, 8'hC0));
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'hFF, 8'h00, 8'h00));
    send_item(npci_pkg::OP_WRITE, 8'd255, rgb(8'h12, 8'h34, 8'h56));
  endtask

  task automatic test_random_traffic();
    int roll, count, span;
    logic [8:0] len;
    logic [7:0] idx;
    rgb_t color;
    while (items_sent < ITEMS_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 6)       len = 9'($urandom_range(200, 256));
      else if (roll < 25) len = 9'($urandom_range(17, 64));
      else if (roll < 35) len = 9'($urandom_range(1, 2));
      else                len = 9'($urandom_range(3, 16));
      set_length(len);
      steady_flow = ($urandom_range(0, 4) == 0);
      fill_span();
      span = active_span();
      count = $urandom_range(40, 120);
      for (int k = 0; k < count && items_sent < ITEMS_TARGET; k++) begin
        if ($urandom_range(0, 99) < 30) begin
          idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, span - 1));
          color = ($urandom_range(0, 3) == 0) ? palette_copy[$urandom_range(0, span - 1)]
                                               : rgb_t'($urandom);
          send_item(npci_pkg::OP_WRITE, idx, color);
        end else begin
          send_item(npci_pkg::OP_QUERY, 8'($urandom), query_color());
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // full palette, lengths past the table size, a zero length and a length of one
  task automatic test_length_limits();
    set_length(9'd256);
    fill_span();
    send_item(npci_pkg::OP_QUERY, 8'h00, palette_copy[255]);
    send_item(npci_pkg::OP_QUERY, 8'hFF, rgb(8'h00, 8'h00, 8'h00));
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'hFF, 8'hFF, 8'hFF));
    repeat (3) send_item(npci_pkg::OP_QUERY, 8'($urandom), query_color());
    set_length(9'd300);
    repeat (3) send_item(npci_pkg::OP_QUERY, 8'($urandom), query_color());
    set_length(9'd511);
    send_item(npci_pkg::OP_QUERY, 8'h00, palette_copy[255]);
    send_item(npci_pkg::OP_QUERY, 8'($urandom), query_color());
    set_length(9'd0);
    send_item(npci_pkg::OP_QUERY, 8'h00, rgb(8'hFF, 8'hFF, 8'hFF));
    send_item(npci_pkg::OP_QUERY, 8'($urandom), rgb_t'($urandom));
    set_length(9'd1);
    send_item(npci_pkg::OP_QUERY, 8'($urandom), rgb_t'($urandom));
  endtask

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        hold = gap_length();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (index_due.size() == 0) begin
        report_mismatch("nearest_index with no query pending", -1, out_tdata);
      end else begin
        want = index_due.pop_front();
        if (out_tdata !== want) report_mismatch("nearest_index", want, out_tdata);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    length_cfg  = 9'd1;
    items_sent  = 0;
    mismatches  = 0;
    steady_flow = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= npci_pkg::OP_WRITE;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= npci_pkg::REG_PALETTE_LENGTH;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_directed_colors();
    test_random_traffic();
    test_length_limits();
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
